/* rtl/controller_map_line_parser_macros.svh */
// Assertion macros for the controller map line parser checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef CONTROLLER_MAP_LINE_PARSER_MACROS_SVH
`define CONTROLLER_MAP_LINE_PARSER_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define CMLP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define CMLP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ctrlmap_pkg.sv */
// Shared types, constants and character helpers for the controller map line parser.
// No dependencies; used by the top level and its checker.
package ctrlmap_pkg;

    localparam int CHAR_W    = 8;
    localparam int ID_W      = 16;
    localparam int MAP_W     = 8;
    localparam int MAP_N     = 8;
    localparam int IDX_W     = $clog2(MAP_N);
    localparam int M_TDATA_W = 2 * ID_W + MAP_N * MAP_W;

    localparam logic [MAP_W-1:0]  MAP_MAX_BIT = 8'd31;
    localparam logic [MAP_W-1:0]  MAP_UNUSED  = 8'd255;
    localparam logic [ID_W-1:0]   ACCUM_SAT   = 16'hFFFF;
    localparam logic [IDX_W-1:0]  LAST_FIELD  = IDX_W'(MAP_N - 1);

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_EQUAL = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_VID,
        PH_PID,
        PH_DEC,
        PH_TRAIL,
        PH_REJECT
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_value(input logic [CHAR_W-1:0] c);
        hex_digit_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r.value = c[3:0];
        end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
            r.value = c[3:0] + 4'd9;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_trail_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic map_value_ok(input logic [MAP_W-1:0] v);
        return (v <= MAP_MAX_BIT) || (v == MAP_UNUSED);
    endfunction

endpackage

/* rtl/controller_map_line_parser.sv */
// Controller map line parser: top level, one character per cycle while not stalled.
// Depends on ctrlmap_pkg.
//
// Usage
//   Feed one text line of the form  hex:hex=d,d,d,d,d,d,d,d  on the s_ channel,
//   one character per request in s_tdata, then one terminator request with
//   s_tlast high (its s_tdata is ignored). Only the terminator produces a
//   request on the m_ channel: m_tuser is the accept flag, m_tdata carries
//   vendor id, product id and the eight map entries, all zero on reject.
// Pipeline and throughput
//   A request lands in the input register at its accept edge, and from there
//   a single pass through the character decode and the decimal accumulate
//   (multiply by ten, add, saturate) updates the state registers. A terminator
//   loads the result into the output register behind m_tvalid. One request per
//   cycle is sustained while no terminator waits on a full output register.
// Stall
//   The output register holds a result until m_tready. Characters keep
//   flowing while a result waits; only a second terminator stalls, in the
//   input register, and s_tready drops until the result is taken.
// Reset
//   aresetn is synchronous, active low: the input and output registers
//   empty and the parser returns to the leading whitespace phase.
module controller_map_line_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ctrlmap_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] char_code
    input  logic                              s_tlast,   // end_of_line
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ctrlmap_pkg::M_TDATA_W-1:0] m_tdata,   // [15:0] vendor_id,
                                                         // [31:16] product_id,
                                                         // [39:32] map_0 .. [95:88] map_7
    output logic                              m_tuser    // accepted
);
    import ctrlmap_pkg::*;

    // Input register stage.
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_eol_reg;

    // Parser state.
    phase_t            phase_reg,   phase_next;
    logic [ID_W-1:0]   accum_reg,   accum_next;
    logic [ID_W-1:0]   vendor_reg,  vendor_next;
    logic [ID_W-1:0]   product_reg, product_next;
    logic              seen_reg,    seen_next;
    logic [IDX_W-1:0]  index_reg,   index_next;
    logic [MAP_W-1:0]  map_reg [MAP_N];

    // Output register stage.
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_user_reg, out_user_next;

    logic fire;        // the held request is parsed this cycle
    logic result_load; // the held request is a terminator and loads the result
    logic map_we;
    logic dec_ok;
    logic accept;

    hex_digit_t       hex;
    logic             is_digit;
    logic [ID_W+3:0]  dec_sum;
    logic [ID_W-1:0]  dec_sat;

    // A terminator waits while the output register is still full.
    assign fire        = in_valid_reg && (!in_eol_reg || !out_valid_reg || m_tready);
    assign result_load = fire && in_eol_reg;
    assign s_tready    = !in_valid_reg || fire;

    // Character decode and decimal accumulate.
    assign hex      = hex_value(in_char_reg);
    assign is_digit = (in_char_reg >= CH_ZERO) && (in_char_reg <= CH_NINE);
    assign dec_sum  = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
                    + {{ID_W{1'b0}}, in_char_reg[3:0]};
    assign dec_sat  = (dec_sum > {4'd0, ACCUM_SAT}) ? ACCUM_SAT : dec_sum[ID_W-1:0];
    assign dec_ok   = seen_reg && ((accum_reg <= {8'd0, MAP_MAX_BIT})
                                || (accum_reg == {8'd0, MAP_UNUSED}));

    // Per-character state update.
    always_comb begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        vendor_next  = vendor_reg;
        product_next = product_reg;
        seen_next    = seen_reg;
        index_next   = index_reg;
        map_we       = 1'b0;
        if (fire && in_eol_reg) begin
            // Terminator: return to the start of a line.
            phase_next   = PH_LEAD;
            accum_next   = '0;
            vendor_next  = '0;
            product_next = '0;
            seen_next    = 1'b0;
            index_next   = '0;
        end else if (fire) begin
            unique case (phase_reg)
                PH_LEAD: begin
                    if (!is_blank(in_char_reg)) begin
                        if (hex.valid) begin
                            accum_next = {12'd0, hex.value};
                            seen_next  = 1'b1;
                            phase_next = PH_VID;
                        end else begin
                            phase_next = PH_REJECT;
                        end
                    end
                end
                PH_VID, PH_PID: begin
                    if (hex.valid) begin
                        accum_next = {accum_reg[ID_W-5:0], hex.value};
                        seen_next  = 1'b1;
                    end else if (!seen_reg) begin
                        phase_next = PH_REJECT;
                    end else if (phase_reg == PH_VID && in_char_reg == CH_COLON) begin
                        vendor_next = accum_reg;
                        phase_next  = PH_PID;
                        accum_next  = '0;
                        seen_next   = 1'b0;
                    end else if (phase_reg == PH_PID && in_char_reg == CH_EQUAL) begin
                        product_next = accum_reg;
                        index_next   = '0;
                        phase_next   = PH_DEC;
                        accum_next   = '0;
                        seen_next    = 1'b0;
                    end else begin
                        phase_next = PH_REJECT;
                    end
                end
                PH_DEC: begin
                    if (is_digit) begin
                        accum_next = dec_sat;
                        seen_next  = 1'b1;
                    end else if (in_char_reg == CH_COMMA && index_reg != LAST_FIELD
                                 && dec_ok) begin
                        // Close this field and advance to the next one.
                        map_we     = 1'b1;
                        index_next = index_reg + 1'b1;
                        accum_next = '0;
                        seen_next  = 1'b0;
                    end else if (is_trail_space(in_char_reg) && index_reg == LAST_FIELD
                                 && dec_ok) begin
                        map_we     = 1'b1;
                        phase_next = PH_TRAIL;
                    end else begin
                        phase_next = PH_REJECT;
                    end
                end
                PH_TRAIL: begin
                    if (!is_trail_space(in_char_reg)) begin
                        phase_next = PH_REJECT;
                    end
                end
                default: begin
                    phase_next = PH_REJECT;
                end
            endcase
        end
    end

    // Result at the terminator. A last field still open is read from the
    // accumulator since it has not been stored yet.
    always_comb begin
        accept = (phase_reg == PH_TRAIL)
              || (phase_reg == PH_DEC && index_reg == LAST_FIELD && dec_ok);
        out_user_next = accept;
        out_data_next = '0;
        if (accept) begin
            out_data_next[ID_W-1:0]      = vendor_reg;
            out_data_next[2*ID_W-1:ID_W] = product_reg;
            for (int i = 0; i < MAP_N; i++) begin
                out_data_next[2*ID_W + i*MAP_W +: MAP_W] = map_reg[i];
            end
            if (phase_reg == PH_DEC) begin
                out_data_next[2*ID_W + (MAP_N-1)*MAP_W +: MAP_W] = accum_reg[MAP_W-1:0];
            end
        end
    end

    // Input register: take a request whenever the stage is empty or drains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            accum_reg   <= '0;
            vendor_reg  <= '0;
            product_reg <= '0;
            seen_reg    <= 1'b0;
            index_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            vendor_reg  <= vendor_next;
            product_reg <= product_next;
            seen_reg    <= seen_next;
            index_reg   <= index_next;
        end
    end

    // Map entries: written only by a closed decimal field, so no reset.
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_reg[index_reg] <= accum_reg[MAP_W-1:0];
        end
    end

    // Output register: hold the result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (result_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (result_load) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

/* rtl/ctrlmap_checker.sv */
// Port-level checker for the controller map line parser, bound to the top level.
// Depends on ctrlmap_pkg and controller_map_line_parser_macros.svh.
`include "controller_map_line_parser_macros.svh"

module ctrlmap_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ctrlmap_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                              m_tuser
);
    import ctrlmap_pkg::*;

    logic maps_ok;

    always_comb begin
        maps_ok = 1'b1;
        for (int i = 0; i < MAP_N; i++) begin
            maps_ok = maps_ok && map_value_ok(m_tdata[2*ID_W + i*MAP_W +: MAP_W]);
        end
    end

    // A stalled result holds its payload.
    `CMLP_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result changed while stalled")
    // A rejected line carries an all-zero payload.
    `CMLP_ASSERT(a_reject_zero, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata == '0,
        "rejected line with nonzero payload")
    // An accepted line only carries bit indexes in range or the unused mark.
    `CMLP_ASSERT(a_accept_maps, aclk, aresetn, m_tvalid && m_tuser |-> maps_ok,
        "accepted line with a map entry out of range")
    // Reset empties the output register.
    `CMLP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind controller_map_line_parser ctrlmap_checker u_ctrlmap_checker (.*);

/* tb/controller_map_line_parser_test.sv */
// Self-checking bench for the controller map line parser: character streams in, verdicts out.
// Depends on ctrlmap_pkg and the controller_map_line_parser top level; needs no files.
`timescale 1ns / 1ps

module controller_map_line_parser_test;
    import ctrlmap_pkg::*;

    localparam logic [CHAR_W-1:0] CH_POUND = 8'h23;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam int TARGET_REQUESTS = 1700;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 10;

    // One request on the input channel: a character, or the terminator.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eol;
    } char_request_t;

    // One verdict on the result channel.
    typedef struct packed {
        logic                        ok;
        logic [ID_W-1:0]             vid;
        logic [ID_W-1:0]             pid;
        logic [MAP_N-1:0][MAP_W-1:0] maps;
    } line_verdict_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata  = '0;     // [7:0] char_code
    logic                 s_tlast  = 1'b0;   // end_of_line
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;           // [15:0] vendor_id, [31:16] product_id,
                                             // [39:32] map_0 .. [95:88] map_7
    logic                 m_tuser;           // accepted

    controller_map_line_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    char_request_t char_requests [$];   // stimulus waiting to be driven
    line_verdict_t expected_verdicts [$];
    logic [CHAR_W-1:0] line_buf [$];    // line under construction

    int requests_total = 0;
    int requests_taken = 0;
    int fail_count     = 0;
    int send_gap       = 0;
    int stall_left     = 0;
    int tx_calm        = 0;
    int rx_calm        = 0;
    int idle_cycles    = 0;

    // ------------------------------------------------------------------
    // Line parser prediction: its own copy of the parse state.
    // ------------------------------------------------------------------
    phase_t            parse_phase  = PH_LEAD;
    int                parse_accum  = 0;
    logic [ID_W-1:0]   vendor_seen  = '0;
    logic [ID_W-1:0]   product_seen = '0;
    logic              digit_taken  = 1'b0;
    int                field_pos    = 0;
    logic [MAP_W-1:0]  map_seen [MAP_N];

    function automatic int nibble_of(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic is_lead_gap(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic is_tail_gap(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    // A decimal field closes cleanly with a digit and a value of 0..31 or 255.
    function automatic logic field_fits();
        return digit_taken && (parse_accum <= 31 || parse_accum == 255);
    endfunction

    task automatic clear_parse();
        int i;
        parse_phase  = PH_LEAD;
        parse_accum  = 0;
        vendor_seen  = '0;
        product_seen = '0;
        digit_taken  = 1'b0;
        field_pos    = 0;
        for (i = 0; i < MAP_N; i++) map_seen[i] = '0;
    endtask

    // Advance the predicted parse by one accepted request; a terminator
    // queues the verdict for the line and clears the parse state.
    task automatic advance_parser(input logic [CHAR_W-1:0] ch, input logic eol);
        int nib;
        int i;
        logic ok;
        line_verdict_t v;
        nib = nibble_of(ch);
        if (eol) begin
            ok = 1'b0;
            if (parse_phase == PH_TRAIL) begin
                ok = 1'b1;
            end else if (parse_phase == PH_DEC && field_pos == MAP_N - 1 && field_fits()) begin
                map_seen[field_pos] = parse_accum[MAP_W-1:0];
                ok = 1'b1;
            end
            v.ok  = ok;
            v.vid = ok ? vendor_seen : '0;
            v.pid = ok ? product_seen : '0;
            for (i = 0; i < MAP_N; i++) v.maps[i] = ok ? map_seen[i] : '0;
            expected_verdicts.push_back(v);
            clear_parse();
            return;
        end
        case (parse_phase)
            PH_LEAD: begin
                if (!is_lead_gap(ch)) begin
                    if (nib < 0) begin
                        parse_phase = PH_REJECT;
                    end else begin
                        parse_accum = nib;
                        digit_taken = 1'b1;
                        parse_phase = PH_VID;
                    end
                end
            end
            PH_VID, PH_PID: begin
                if (nib >= 0) begin
                    parse_accum = ((parse_accum << 4) | nib) & 16'hFFFF;
                    digit_taken = 1'b1;
                end else if (!digit_taken) begin
                    parse_phase = PH_REJECT;
                end else if (parse_phase == PH_VID && ch == CH_COLON) begin
                    vendor_seen = parse_accum[ID_W-1:0];
                    parse_phase = PH_PID;
                    parse_accum = 0;
                    digit_taken = 1'b0;
                end else if (parse_phase == PH_PID && ch == CH_EQUAL) begin
                    product_seen = parse_accum[ID_W-1:0];
                    field_pos    = 0;
                    parse_phase  = PH_DEC;
                    parse_accum  = 0;
                    digit_taken  = 1'b0;
                end else begin
                    parse_phase = PH_REJECT;
                end
            end
            PH_DEC: begin
                if (ch >= "0" && ch <= "9") begin
                    // saturate instead of wrapping
                    parse_accum = parse_accum * 10 + (int'(ch) - int'("0"));
                    if (parse_accum > 65535) parse_accum = 65535;
                    digit_taken = 1'b1;
                end else if (ch == CH_COMMA && field_pos < MAP_N - 1 && field_fits()) begin
                    map_seen[field_pos] = parse_accum[MAP_W-1:0];
                    field_pos++;
                    parse_accum = 0;
                    digit_taken = 1'b0;
                end else if (is_tail_gap(ch) && field_pos == MAP_N - 1 && field_fits()) begin
                    map_seen[field_pos] = parse_accum[MAP_W-1:0];
                    parse_phase = PH_TRAIL;
                end else begin
                    parse_phase = PH_REJECT;
                end
            end
            PH_TRAIL: begin
                if (!is_tail_gap(ch)) parse_phase = PH_REJECT;
            end
            default: parse_phase = PH_REJECT;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction: lines are built in line_buf, then committed
    // as character requests followed by a terminator request.
    // ------------------------------------------------------------------
    task automatic put_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    function automatic logic [CHAR_W-1:0] stray_byte();
        if ($urandom_range(0, 9) == 0) return CH_NUL;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic commit_line();
        char_request_t r;
        while (line_buf.size() > 0) begin
            r.ch  = line_buf.pop_front();
            r.eol = 1'b0;
            char_requests.push_back(r);
        end
        // the terminator's byte is don't-care; randomize it anyway
        r.ch  = CHAR_W'($urandom_range(0, 255));
        r.eol = 1'b1;
        char_requests.push_back(r);
    endtask

    task automatic put_blanks();
        int n;
        int i;
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    // Hex id: mostly 1..4 digits, some longer to hit the low-16 truncation.
    task automatic emit_hex_field(input bit clean);
        int n;
        int i;
        int v;
        if (!clean && $urandom_range(0, 9) == 0) n = 0;
        else if ($urandom_range(0, 9) < 2) n = $urandom_range(5, 8);
        else n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            v = $urandom_range(0, 15);
            if (v < 10) line_buf.push_back(CH_ZERO + CHAR_W'(v));
            else line_buf.push_back(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + CHAR_W'(v - 10));
        end
    endtask

    // Map entry: clean lines draw only legal forms; others add empty,
    // out-of-range and over-long numbers.
    task automatic emit_map_field(input bit clean);
        int pick;
        int v;
        int i;
        int n;
        pick = clean ? $urandom_range(0, 69) : $urandom_range(0, 99);
        if (pick < 45) begin
            put_str($sformatf("%0d", $urandom_range(0, 31)));
        end else if (pick < 60) begin
            put_str("255");
        end else if (pick < 70) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) line_buf.push_back(CH_ZERO);
            put_str($sformatf("%0d", $urandom_range(0, 1) ? $urandom_range(0, 31) : 255));
        end else if (pick < 80) begin
            // no digits at all
        end else if (pick < 90) begin
            v = $urandom_range(32, 999);
            if (v == 255) v = 256;
            put_str($sformatf("%0d", v));
        end else begin
            n = $urandom_range(5, 9);
            for (i = 0; i < n; i++) line_buf.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        end
    endtask

    task automatic compose_line();
        int kind;
        int n;
        int i;
        int pos;
        int fields;
        bit clean;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            // comment line
            put_blanks();
            line_buf.push_back(CH_POUND);
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++) line_buf.push_back(CHAR_W'($urandom_range(8'h20, 8'h7E)));
        end else if (kind < 10) begin
            put_blanks();
        end else if (kind < 14) begin
            n = $urandom_range(1, 30);
            for (i = 0; i < n; i++) line_buf.push_back(stray_byte());
        end else begin
            clean = ($urandom_range(0, 99) < 60);
            put_blanks();
            emit_hex_field(clean);
            line_buf.push_back(CH_COLON);
            emit_hex_field(clean);
            line_buf.push_back(CH_EQUAL);
            fields = MAP_N;
            if (!clean) begin
                n = $urandom_range(0, 99);
                if (n < 5) fields = MAP_N - 1;
                else if (n < 10) fields = MAP_N + 1;
            end
            for (i = 0; i < fields; i++) begin
                if (i > 0) line_buf.push_back(CH_COMMA);
                emit_map_field(clean);
            end
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0:       line_buf.push_back(CH_SPACE);
                    1:       line_buf.push_back(CH_TAB);
                    2:       line_buf.push_back(CH_CR);
                    default: line_buf.push_back(CH_LF);
                endcase
            end
            if (!clean && $urandom_range(0, 99) < 5)
                line_buf.push_back(CHAR_W'($urandom_range(8'h21, 8'h7E)));
            if (!clean && $urandom_range(0, 99) < 40) begin
                pos = $urandom_range(0, line_buf.size() - 1);
                if ($urandom_range(0, 3) == 0) begin
                    // cut the line short
                    while (line_buf.size() > pos) void'(line_buf.pop_back());
                end else begin
                    line_buf[pos] = stray_byte();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_verdict(input logic ok, input logic [M_TDATA_W-1:0] data);
        line_verdict_t e;
        int i;
        if (expected_verdicts.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected result request: accepted=%0d data=%h", ok, data);
            return;
        end
        e = expected_verdicts.pop_front();
        compare_field("accepted", e.ok, ok);
        compare_field("vendor_id", e.vid, data[ID_W-1:0]);
        compare_field("product_id", e.pid, data[2*ID_W-1:ID_W]);
        for (i = 0; i < MAP_N; i++)
            compare_field($sformatf("map_%0d", i), e.maps[i], data[2*ID_W + MAP_W*i +: MAP_W]);
    endtask

    // Gap draw: mostly none or short, a few long, and now and then a calm
    // stretch with no gaps at all.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: predict on each accepted request, then load the next one
    // once the slot is free and any gap has run out.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        char_request_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_parser(s_tdata, s_tlast);
                requests_taken++;
            end
            // hold the request while it waits for s_tready
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (char_requests.size() > 0) begin
                    nxt = char_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.eol;
                    send_gap <= pick_gap(tx_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result, then drop m_tready for a while
    // at random; also stall now and then while nothing is waiting.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : take_results
        int g;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            check_verdict(m_tuser, m_tdata);
            g = pick_gap(rx_calm);
            stall_left <= g;
            m_tready   <= (g == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (rx_calm == 0 && $urandom_range(0, 19) == 0) begin
            stall_left <= $urandom_range(1, 8);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no request moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** controller_map_line_parser: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_parse();

        // Directed lines: blank, comment, and one legal line with mixed-case
        // hex, the largest bit index, the unused marker and a CR tail.
        commit_line();
        put_str("#");
        commit_line();
        put_str(" \tf:E=31,255,0,1,2,3,4,9\r");
        commit_line();

        // Random lines, mostly well formed with random content.
        while (char_requests.size() < TARGET_REQUESTS) begin
            compose_line();
            commit_line();
        end
        requests_total = char_requests.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // drain: every request taken, every verdict seen, then a short tail
        while (requests_taken < requests_total) @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("** controller_map_line_parser: PASSED **");
        end else begin
            $display("** controller_map_line_parser: FAILED **");
        end
        $finish;
    end

endmodule
